@@ sv/snfs_pkg.sv @@
package snfs_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned SlotOutW = 3;

  // controller to datapath
  typedef struct packed {
    logic do_push;
    logic reject_full;
    logic reject_empty;
    logic pop_start;
    logic pop_read_value;
    logic pop_finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic out_free;
  } dp_status_t;

endpackage

@@ sv/snfs_ctrl.sv @@
module snfs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 opcode_i,
  input  snfs_pkg::dp_status_t sts_i,
  output logic                 in_stall_o,
  output snfs_pkg::dp_cmd_t    cmd_o
);
  import snfs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_SLOT,
    S_POP_DONE
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  always_comb begin
    in_stall_o = (state_q != S_IDLE) || !sts_i.out_free;
    accept     = in_valid_i && !in_stall_o;
    cmd_o      = '0;
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_PUSH) begin
            if (sts_i.full) begin
              cmd_o.reject_full = 1'b1;
            end else begin
              cmd_o.do_push = 1'b1;
            end
          end else if (sts_i.empty) begin
            cmd_o.reject_empty = 1'b1;
          end else begin
            cmd_o.pop_start = 1'b1;
            state_d         = S_POP_SLOT;
          end
        end
      end
      S_POP_SLOT: begin
        cmd_o.pop_read_value = 1'b1;
        state_d              = S_POP_DONE;
      end
      S_POP_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.pop_finish = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/snfs_datapath.sv @@
module snfs_datapath #(
  parameter int unsigned POOL_SLOTS = 5
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [snfs_pkg::ValueW-1:0]    push_value_i,
  input  snfs_pkg::dp_cmd_t                     cmd_i,
  output snfs_pkg::dp_status_t                  sts_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [1:0]                            status_o,
  output logic signed [snfs_pkg::ValueW-1:0]    popped_value_o,
  output logic [snfs_pkg::SlotOutW-1:0]         slot_index_o
);
  import snfs_pkg::*;

  localparam int unsigned IdxW = $clog2(POOL_SLOTS);
  localparam int unsigned CntW = $clog2(POOL_SLOTS + 1);

  logic [POOL_SLOTS-1:0] in_use_q;
  logic [IdxW-1:0]       ptr_q;
  logic [CntW-1:0]       depth_q;

  logic signed [ValueW-1:0] value_mem [POOL_SLOTS];
  logic [IdxW-1:0]          order_mem [POOL_SLOTS];
  logic [IdxW-1:0]          order_rd_q;
  logic signed [ValueW-1:0] value_rd_q;

  logic                     out_valid_q;
  status_e                  status_q;
  logic signed [ValueW-1:0] value_q;
  logic [SlotOutW-1:0]      slot_q;

  logic [POOL_SLOTS-1:0] free_vec, free_hi;
  logic [IdxW-1:0]       pick_hi, pick_all, free_slot;
  logic [CntW-1:0]       depth_dec;
  logic [IdxW-1:0]       top_idx, push_idx;
  logic [IdxW+SlotOutW-1:0] push_slot_ext, pop_slot_ext;
  logic                  out_free, out_load;

  // next-fit search: first free slot at or after the pointer, else the lowest free one
  always_comb begin
    free_vec = ~in_use_q;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      free_hi[i] = free_vec[i] && (IdxW'(i) >= ptr_q);
    end
    pick_hi  = '0;
    pick_all = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (free_hi[i]) pick_hi = IdxW'(i);
      if (free_vec[i]) pick_all = IdxW'(i);
    end
    free_slot = (|free_hi) ? pick_hi : pick_all;
  end

  assign depth_dec     = depth_q - CntW'(1);
  assign top_idx       = depth_dec[IdxW-1:0];
  assign push_idx      = depth_q[IdxW-1:0];
  assign push_slot_ext = (IdxW + SlotOutW)'(free_slot);
  assign pop_slot_ext  = (IdxW + SlotOutW)'(order_rd_q);

  assign sts_o.full     = (depth_q == CntW'(POOL_SLOTS));
  assign sts_o.empty    = (depth_q == '0);
  assign out_free       = !out_valid_q || !out_stall_i;
  assign sts_o.out_free = out_free;
  assign out_load       = cmd_i.do_push || cmd_i.reject_full || cmd_i.reject_empty ||
                          cmd_i.pop_finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      ptr_q    <= '0;
      depth_q  <= '0;
    end else begin
      if (cmd_i.do_push) begin
        in_use_q[free_slot] <= 1'b1;
        ptr_q               <= free_slot;
        depth_q             <= depth_q + CntW'(1);
      end
      if (cmd_i.pop_start) begin
        depth_q <= depth_dec;
      end
      if (cmd_i.pop_read_value) begin
        in_use_q[order_rd_q] <= 1'b0;
      end
    end
  end

  // slot value and stack order memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_push) begin
      value_mem[free_slot] <= push_value_i;
      order_mem[push_idx]  <= free_slot;
    end
    if (cmd_i.pop_start) begin
      order_rd_q <= order_mem[top_idx];
    end
    if (cmd_i.pop_read_value) begin
      value_rd_q <= value_mem[order_rd_q];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (cmd_i.do_push) begin
        status_q <= ST_PUSHED;
        value_q  <= '0;
        slot_q   <= push_slot_ext[SlotOutW-1:0];
      end else if (cmd_i.pop_finish) begin
        status_q <= ST_POPPED;
        value_q  <= value_rd_q;
        slot_q   <= pop_slot_ext[SlotOutW-1:0];
      end else if (cmd_i.reject_full) begin
        status_q <= ST_FULL;
        value_q  <= '0;
        slot_q   <= '0;
      end else begin
        status_q <= ST_EMPTY;
        value_q  <= '0;
        slot_q   <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = value_q;
  assign slot_index_o   = slot_q;

endmodule

@@ sv/stack_with_next_fit_slot_pool_core.sv @@
// LIFO stack of signed 32-bit scores kept in a pool of POOL_SLOTS slots. A push
// takes the first free slot found by a rotating pointer that starts at the slot
// taken last and wraps round the pool; the result carries that slot number. A pop
// frees the top slot and returns its value and slot number. Push on a full stack
// and pop on an empty one are refused with status full / empty and zero fields.
// Slot numbers wider than three bits are shown masked to their low three bits.
// A push, or any refused transaction, has its result in the output register on
// the next edge. A successful pop runs through two dependent registered memory
// reads: the stack order memory gives the top slot number, which then addresses
// the slot value memory; the result then waits for a free output register. One
// transaction is in flight at a time; input stall is also raised while a result
// waits in the output register and the downstream side stalls. The memories need
// no clearing after reset, as every entry is written before it is read.
module stack_with_next_fit_slot_pool_core #(
  parameter int unsigned POOL_SLOTS = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic signed [snfs_pkg::ValueW-1:0]  push_value_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic signed [snfs_pkg::ValueW-1:0]  popped_value_o,
  output logic [snfs_pkg::SlotOutW-1:0]       slot_index_o
);
  import snfs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  // sequencer: decodes each transaction and steps a pop through its reads
  snfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // slot pool, used marks, search pointer, depth and output register
  snfs_datapath #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_value_i   (push_value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .slot_index_o   (slot_index_o)
  );

endmodule

@@ sv/snfs_checker.sv @@
module snfs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                opcode_i,
  input logic signed [snfs_pkg::ValueW-1:0]  push_value_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [1:0]                          status_o,
  input logic signed [snfs_pkg::ValueW-1:0]  popped_value_o,
  input logic [snfs_pkg::SlotOutW-1:0]       slot_index_o
);
  import snfs_pkg::*;

  // a stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(popped_value_o) && $stable(slot_index_o))
    else $error("stalled result changed");

  // a stalled input transaction stays and holds its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(opcode_i) &&
      $stable(push_value_i))
    else $error("stalled input transaction changed");

  // a push is answered in the next cycle, pushed or full
  a_push_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (opcode_i == OP_PUSH) |=>
      out_valid_o && (status_o == ST_PUSHED || status_o == ST_FULL))
    else $error("push not answered next cycle");

  // refused transactions carry zero value and slot
  a_refuse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_EMPTY) |->
      popped_value_o == '0 && slot_index_o == '0)
    else $error("refused transaction with non-zero fields");

  // no new transaction while a result is held back
  a_stall_couple: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result stalled");

endmodule

bind stack_with_next_fit_slot_pool_core snfs_checker u_snfs_checker (.*);

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import snfs_pkg::*;

  localparam int unsigned POOL_SLOTS = 5;
  localparam logic signed [ValueW-1:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] SCORE_MAX = 32'sh7fff_ffff;
  // transactions left in the queue when idling stops for the closing stretch
  localparam int unsigned TAIL_ITEMS = 100;

  // one stack request waiting to go out; hold_for_drain makes the sender
  // wait until every outstanding result has been seen
  typedef struct {
    logic                     op;
    logic signed [ValueW-1:0] score;
    bit                       hold_for_drain;
  } stack_req_t;

  // what the block should report for one transaction
  typedef struct {
    status_e                  status;
    logic signed [ValueW-1:0] score;
    logic [SlotOutW-1:0]      slot;
  } stack_resp_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i   = 1'b0;
  logic                       in_stall_o;
  logic                       opcode_i     = OP_PUSH;
  logic signed [ValueW-1:0]   push_value_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i  = 1'b0;
  logic [1:0]                 status_o;
  logic signed [ValueW-1:0]   popped_value_o;
  logic [SlotOutW-1:0]        slot_index_o;

  stack_req_t  req_pending_q[$];
  stack_resp_t resp_expect_q[$];
  int unsigned n_fail     = 0;
  int unsigned n_accepted = 0;

  // shadow copy of the slot pool and the lifo order
  logic signed [ValueW-1:0] pool_score [POOL_SLOTS];
  bit                       pool_busy  [POOL_SLOTS];
  int unsigned              lifo_slot  [POOL_SLOTS];
  int unsigned              lifo_depth   = 0;
  int unsigned              next_fit_ptr = 0;

  stack_with_next_fit_slot_pool_core #(
    .POOL_SLOTS(POOL_SLOTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .popped_value_o(popped_value_o),
    .slot_index_o  (slot_index_o)
  );

  // works out the response to one accepted request and updates the shadow pool
  function automatic stack_resp_t predict_stack_op(logic op, logic signed [ValueW-1:0] score);
    stack_resp_t r;
    int unsigned p;
    int unsigned s;
    bit          found;
    r.status = ST_PUSHED;
    r.score  = '0;
    r.slot   = '0;
    if (op == OP_PUSH) begin
      if (lifo_depth >= POOL_SLOTS) begin
        r.status = ST_FULL;
        return r;
      end
      // next-fit search from where the last slot was taken, wrapping round
      p = next_fit_ptr % POOL_SLOTS;
      found = 1'b0;
      for (int i = 0; i < POOL_SLOTS && !found; i++) begin
        if (!pool_busy[p]) found = 1'b1;
        else p = (p + 1) % POOL_SLOTS;
      end
      next_fit_ptr = p;
      if (!found) begin
        r.status = ST_FULL;
        return r;
      end
      pool_score[p] = score;
      pool_busy[p]  = 1'b1;
      lifo_slot[lifo_depth] = p;
      lifo_depth++;
      r.slot = p[SlotOutW-1:0];
    end else begin
      if (lifo_depth == 0) begin
        r.status = ST_EMPTY;
        return r;
      end
      // pop leaves the search pointer where it is
      lifo_depth--;
      s = lifo_slot[lifo_depth] % POOL_SLOTS;
      pool_busy[s] = 1'b0;
      r.status = ST_POPPED;
      r.score  = pool_score[s];
      r.slot   = s[SlotOutW-1:0];
    end
    return r;
  endfunction

  // closing stretch runs with no idling on either side
  function automatic bit in_tail();
    return req_pending_q.size() < TAIL_ITEMS;
  endfunction

  function automatic logic signed [ValueW-1:0] pick_score();
    case ($urandom_range(0, 7))
      0:       return SCORE_MIN;
      1:       return SCORE_MAX;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_req(logic op, logic signed [ValueW-1:0] score, bit drain = 1'b0);
    stack_req_t q;
    q.op             = op;
    q.score          = score;
    q.hold_for_drain = drain;
    req_pending_q.push_back(q);
  endtask

  // clock and reset
  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // stimulus: directed sequence first, then push and pop bursts
  initial begin
    int unsigned n_push;
    int unsigned n_pop;
    // pop straight after reset finds the stack empty
    queue_req(OP_POP, SCORE_MAX);
    // fill all five slots with the extreme scores, then one push too many
    queue_req(OP_PUSH, SCORE_MIN);
    queue_req(OP_PUSH, SCORE_MAX);
    queue_req(OP_PUSH, 32'sd0);
    queue_req(OP_PUSH, -32'sd1);
    queue_req(OP_PUSH, 32'sd1);
    queue_req(OP_PUSH, 32'sh5a5a_5a5a);
    // free the top two, then refill: the pointer sits on slot four, and the
    // second push has to wrap round past the used low slots
    queue_req(OP_POP, 32'sh0);
    queue_req(OP_POP, 32'sh0);
    queue_req(OP_PUSH, 32'sd7);
    queue_req(OP_PUSH, 32'sd8);
    queue_req(OP_POP, 32'sh0);
    queue_req(OP_POP, 32'sh0);
    queue_req(OP_POP, 32'sh0);
    queue_req(OP_POP, 32'sh0);
    // sender waits here for every result before going on
    queue_req(OP_PUSH, 32'sh1234_5678, 1'b1);
    queue_req(OP_PUSH, 32'shdead_beef);
    queue_req(OP_PUSH, 32'sh0f0f_0f0f);
    queue_req(OP_POP, 32'sh0);
    queue_req(OP_POP, 32'sh0);
    queue_req(OP_POP, 32'sh0);
    queue_req(OP_POP, 32'sh0);
    // empty again, pop with an all-ones payload that must be ignored
    queue_req(OP_POP, -32'sd1);

    // random part: bursts that walk the depth up to full and back to empty,
    // with a sprinkling of arbitrary transactions
    while (req_pending_q.size() < 1050) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_req($urandom_range(0, 1) ? OP_POP : OP_PUSH, pick_score());
      end else begin
        n_push = $urandom_range(1, 7);
        n_pop  = $urandom_range(1, 7);
        for (int i = 0; i < n_push; i++)
          queue_req(OP_PUSH, pick_score(), (req_pending_q.size() == 500) && (i == 0));
        for (int i = 0; i < n_pop; i++)
          queue_req(OP_POP, $urandom);
      end
    end
  end

  // driver: presents queued requests, records the expected response at the
  // accepting edge and inserts idle bursts between transactions
  int unsigned gap_left = 0;
  bit          idle_on  = 1'b1;

  always @(posedge clk_i) begin : req_driver
    bit         free;
    bit         nxt_valid;
    stack_req_t cur;
    if (rst_ni) begin
      free      = !in_valid_i;
      nxt_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        resp_expect_q.push_back(predict_stack_op(opcode_i, push_value_i));
        free      = 1'b1;
        nxt_valid = 1'b0;
        n_accepted++;
        // switch between bursty and back-to-back stretches now and then
        if (n_accepted % 64 == 0) idle_on = $urandom_range(0, 2) != 0;
        if (idle_on && !in_tail() && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 12);
      end
      if (free) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_pending_q.size() > 0 &&
                     !(req_pending_q[0].hold_for_drain && resp_expect_q.size() != 0)) begin
          cur = req_pending_q.pop_front();
          opcode_i     <= cur.op;
          push_value_i <= cur.score;
          nxt_valid    = 1'b1;
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // monitor: checks each accepted result against the oldest expectation and
  // drives random stall bursts on the result side
  int unsigned stall_left = 0;
  int unsigned mon_cycles = 0;
  bit          stall_on   = 1'b1;

  always @(posedge clk_i) begin : resp_monitor
    stack_resp_t exp_r;
    bit          nxt_stall;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (resp_expect_q.size() == 0) begin
          $display("%0t: unexpected result: status %0d value %h slot %0d",
                   $time, status_o, popped_value_o, slot_index_o);
          n_fail++;
        end else begin
          exp_r = resp_expect_q.pop_front();
          if (status_o !== exp_r.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, exp_r.status, status_o);
            n_fail++;
          end
          if (popped_value_o !== exp_r.score) begin
            $display("%0t: popped_value mismatch: expected %h actual %h",
                     $time, exp_r.score, popped_value_o);
            n_fail++;
          end
          if (slot_index_o !== exp_r.slot) begin
            $display("%0t: slot_index mismatch: expected %0d actual %0d",
                     $time, exp_r.slot, slot_index_o);
            n_fail++;
          end
        end
      end
      mon_cycles++;
      if (mon_cycles % 256 == 0) stall_on = $urandom_range(0, 2) != 0;
      if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (stall_on && !in_tail() && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        nxt_stall  = 1'b1;
      end else begin
        nxt_stall = 1'b0;
      end
      out_stall_i <= nxt_stall;
    end
  end

  // end of run: all requests accepted, all results seen, then a short settle
  initial begin
    @(posedge rst_ni);
    while (req_pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (resp_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("stack_with_next_fit_slot_pool_core test passed");
    end else begin
      $display("stack_with_next_fit_slot_pool_core test failed");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("stack_with_next_fit_slot_pool_core test failed");
    $finish;
  end

endmodule

@@ sim.f @@
sv/snfs_pkg.sv
sv/snfs_ctrl.sv
sv/snfs_datapath.sv
sv/stack_with_next_fit_slot_pool_core.sv
sv/snfs_checker.sv
tb/sv/tb_top.sv
